// ===== design/nst_pkg.sv =====
package nst_pkg;

  localparam logic [3:0] KIND_CREATE   = 4'd0;
  localparam logic [3:0] KIND_SET      = 4'd1;
  localparam logic [3:0] KIND_DELETE   = 4'd2;
  localparam logic [3:0] KIND_LOOKUP   = 4'd3;
  localparam logic [3:0] KIND_READ     = 4'd4;
  localparam logic [3:0] KIND_HBEAT    = 4'd5;
  localparam logic [3:0] KIND_TICK     = 4'd6;
  localparam logic [3:0] KIND_LIST_ON  = 4'd7;
  localparam logic [3:0] KIND_LIST_ALL = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_ONLINE  = 2'd1;
  localparam logic [1:0] EV_OFFLINE = 2'd2;

  localparam logic CFG_NORMAL = 1'b0;
  localparam logic CFG_SLEEPY = 1'b1;

  localparam int MAX_RES = 16;
  localparam logic [29:0] NORMAL_RST = 30'd1000;
  localparam logic [29:0] SLEEPY_RST = 30'd10000;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  slot;
    logic [31:0] node_uid;
    logic [31:0] node_type;
    logic        sleeper;
    logic [7:0]  secret_key;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  event_res;
    logic [3:0]  result_slot;
    logic [31:0] result_uid;
    logic [31:0] result_type;
    logic        result_sleeper;
    logic        result_online;
    logic        last;
  } out_t;

endpackage

// ===== design/node_slot_table_with_heartbeat.sv =====
// Node slot table with heartbeat supervision.
// Input channel: drive in_data and raise start; the item is taken at a clock
// edge where start is high and busy is low. busy stays high until the last
// result of that item has been issued.
// Result channel: each result sits on out_data for one cycle with out_valid
// high; the receiver cannot stall it. Lists give one result per matching slot
// (one not-found result if none), the final one with last set; others give one.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 normal
// period, 1 sleepy period) at the clock edge; write only while not busy.
// Sequence: set, delete and heartbeat answer from S_EXEC; read and tick
// go through S_EXEC and S_CMP; create checks one slot per S_EXEC step;
// lookup and list visit each slot in an S_EXEC and an S_CMP step through
// the single registered read port of the entry memory, and list ends in
// S_FLUSH. busy drops in the cycle the final result is on the ports,
// so the next item can be taken at the edge that accepts that result.
// Reset clears the allocated and online bits, time and poll pointer, and
// reloads the period registers with their defaults; entry memory contents
// are only used for allocated slots.
module node_slot_table_with_heartbeat #(
  parameter int SLOTS      = 16,
  parameter int TYPE_BYTES = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  nst_pkg::in_t   in_data,
  output logic           out_valid,
  output nst_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [29:0]    cfg_wdata
);
  import nst_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = (TYPE_BYTES * 8 < 32) ? TYPE_BYTES * 8 : 32;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_CMP   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  typedef struct packed {
    logic [31:0]   uid;
    logic [TW-1:0] ntype;
    logic          sleeper;
    logic [7:0]    key;
  } entry_t;

  state_t          state_r, state_nxt;
  in_t             item_r, item_nxt;
  logic [SW:0]     idx_r, idx_nxt;
  logic [SLOTS-1:0] alloc_r, alloc_nxt;
  logic [SLOTS-1:0] online_r, online_nxt;
  logic [31:0]     now_r, now_nxt;
  logic [SW-1:0]   poll_r, poll_nxt;
  logic [29:0]     normal_r, sleepy_r;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  out_t            pend_r, pend_nxt;
  logic [5:0]      cnt_r, cnt_nxt;

  entry_t          ent_mem [SLOTS];
  logic [31:0]     ls_mem [SLOTS];
  entry_t          rd_ent_r;
  logic [31:0]     rd_ls_r;

  logic            ent_we, ls_we, rd_en;
  logic [SW-1:0]   ent_waddr, ls_waddr, rd_addr;
  entry_t          ent_wdata;
  logic [31:0]     ls_wdata;

  logic [31:0]     slot_w, idx_w;
  logic [SW-1:0]   sidx, cidx;
  logic            slot_ok;
  logic [31:0]     per3, age;
  logic [29:0]     per;

  assign slot_w  = 32'(item_r.slot);
  assign sidx    = slot_w[SW-1:0];
  assign slot_ok = slot_w < 32'(SLOTS);
  assign idx_w   = 32'(idx_r);
  assign cidx    = idx_r[SW-1:0];
  assign per     = rd_ent_r.sleeper ? sleepy_r : normal_r;
  assign per3    = {2'b00, per} + {1'b0, per, 1'b0};
  assign age     = now_r - rd_ls_r;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_t o;
    o              = '0;
    state_nxt      = state_r;
    item_nxt       = item_r;
    idx_nxt        = idx_r;
    alloc_nxt      = alloc_r;
    online_nxt     = online_r;
    now_nxt        = now_r;
    poll_nxt       = poll_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    cnt_nxt        = cnt_r;
    ent_we         = 1'b0;
    ent_waddr      = sidx;
    ent_wdata      = '{uid: item_r.node_uid, ntype: item_r.node_type[TW-1:0],
                       sleeper: item_r.sleeper, key: item_r.secret_key};
    ls_we          = 1'b0;
    ls_waddr       = sidx;
    ls_wdata       = '0;
    rd_en          = 1'b0;
    rd_addr        = cidx;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt       = in_data;
          pend_valid_nxt = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = S_EXEC;
          if (in_data.kind == KIND_CREATE) begin
            idx_nxt = (SW + 1)'(1);
          end else if (in_data.kind == KIND_TICK) begin
            idx_nxt = {1'b0, poll_r};
          end else begin
            idx_nxt = '0;
          end
        end
      end

      S_EXEC: begin
        o.last = 1'b1;
        case (item_r.kind)
          KIND_CREATE: begin
            if (idx_w >= 32'(SLOTS)) begin
              o.status      = ST_NOTFOUND;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else if (!alloc_r[cidx]) begin
              ent_we            = 1'b1;
              ent_waddr         = cidx;
              ls_we             = 1'b1;
              ls_waddr          = cidx;
              alloc_nxt[cidx]   = 1'b1;
              online_nxt[cidx]  = 1'b0;
              o.result_slot     = idx_w[3:0];
              out_valid_nxt     = 1'b1;
              state_nxt         = S_IDLE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          KIND_SET: begin
            o.result_slot = item_r.slot;
            if (!slot_ok) begin
              o.status = ST_RANGE;
            end else begin
              ent_we           = 1'b1;
              ls_we            = 1'b1;
              alloc_nxt[sidx]  = 1'b1;
              online_nxt[sidx] = 1'b0;
            end
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          KIND_DELETE, KIND_READ, KIND_HBEAT: begin
            o.result_slot = item_r.slot;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (!slot_ok) begin
              o.status = ST_RANGE;
            end else if (!alloc_r[sidx]) begin
              o.status = ST_NOTFOUND;
            end else if (item_r.kind == KIND_DELETE) begin
              alloc_nxt[sidx]  = 1'b0;
              online_nxt[sidx] = 1'b0;
            end else if (item_r.kind == KIND_HBEAT) begin
              ls_we    = 1'b1;
              ls_wdata = now_r;
              if (!online_r[sidx]) begin
                online_nxt[sidx] = 1'b1;
                o.event_res      = EV_ONLINE;
              end
            end else begin
              // fetch the entry, answer from the registered read data
              rd_en         = 1'b1;
              rd_addr       = sidx;
              out_valid_nxt = 1'b0;
              state_nxt     = S_CMP;
            end
          end
          KIND_TICK: begin
            now_nxt   = now_r + 32'd1;
            poll_nxt  = (32'(poll_r) + 32'd1 >= 32'(SLOTS)) ? '0 : poll_r + 1'b1;
            rd_en     = 1'b1;
            state_nxt = S_CMP;
          end
          KIND_LOOKUP, KIND_LIST_ON, KIND_LIST_ALL: begin
            rd_en     = 1'b1;
            state_nxt = S_CMP;
          end
          default: begin
            o.status      = ST_NOTFOUND;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
        if (out_valid_nxt) begin
          out_nxt = o;
        end
      end

      S_CMP: begin
        case (item_r.kind)
          KIND_READ: begin
            o.result_slot    = item_r.slot;
            o.result_uid     = rd_ent_r.uid;
            o.result_type    = 32'(rd_ent_r.ntype);
            o.result_sleeper = rd_ent_r.sleeper;
            o.result_online  = online_r[sidx];
            o.last           = 1'b1;
            out_nxt          = o;
            out_valid_nxt    = 1'b1;
            state_nxt        = S_IDLE;
          end
          KIND_TICK: begin
            o.result_slot = idx_w[3:0];
            o.last        = 1'b1;
            if (alloc_r[cidx] && online_r[cidx] && age > per3) begin
              online_nxt[cidx] = 1'b0;
              o.event_res      = EV_OFFLINE;
            end
            out_nxt       = o;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          KIND_LOOKUP: begin
            if (alloc_r[cidx] && rd_ent_r.uid == item_r.node_uid) begin
              o.result_slot = idx_w[3:0];
              o.last        = 1'b1;
              out_nxt       = o;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else if (idx_w + 32'd1 >= 32'(SLOTS)) begin
              o.status      = ST_NOTFOUND;
              o.last        = 1'b1;
              out_nxt       = o;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_EXEC;
            end
          end
          default: begin
            // list: hold a found slot until the next match; the flush sets last
            state_nxt = S_EXEC;
            if (alloc_r[cidx] && (item_r.kind == KIND_LIST_ALL || online_r[cidx])) begin
              if (pend_valid_r) begin
                out_nxt       = pend_r;
                out_valid_nxt = 1'b1;
              end
              o.result_slot    = idx_w[3:0];
              o.result_uid     = rd_ent_r.uid;
              o.result_type    = 32'(rd_ent_r.ntype);
              o.result_sleeper = rd_ent_r.sleeper;
              o.result_online  = online_r[cidx];
              pend_nxt         = o;
              pend_valid_nxt   = 1'b1;
              cnt_nxt          = cnt_r + 1'b1;
              if (32'(cnt_r) + 32'd1 >= 32'(MAX_RES)) begin
                state_nxt = S_FLUSH;
              end
            end
            if (idx_w + 32'd1 >= 32'(SLOTS)) begin
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        endcase
      end

      S_FLUSH: begin
        if (pend_valid_r) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
        end else begin
          o.status = ST_NOTFOUND;
          o.last   = 1'b1;
          out_nxt  = o;
        end
        out_valid_nxt  = 1'b1;
        pend_valid_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      alloc_r      <= '0;
      online_r     <= '0;
      now_r        <= '0;
      poll_r       <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      cnt_r        <= '0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      alloc_r      <= alloc_nxt;
      online_r     <= online_nxt;
      now_r        <= now_nxt;
      poll_r       <= poll_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r <= NORMAL_RST;
      sleepy_r <= SLEEPY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NORMAL: normal_r <= cfg_wdata;
        CFG_SLEEPY: sleepy_r <= cfg_wdata;
        default:    normal_r <= normal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ls_we) begin
      ls_mem[ls_waddr] <= ls_wdata;
    end
    if (rd_en) begin
      rd_ent_r <= ent_mem[rd_addr];
      rd_ls_r  <= ls_mem[rd_addr];
    end
  end

endmodule
